// ===== hw/rtl/kalman_filter_2state_position_defines.svh =====
// Assertion macros for the Kalman filter block
`ifndef KALMAN_FILTER_2STATE_POSITION_DEFINES_SVH
`define KALMAN_FILTER_2STATE_POSITION_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define KFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kfp check failed");

// consequent checked in the same cycle
`define KFP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kfp check failed");

`endif

// ===== hw/rtl/kfp_pkg.sv =====
package kfp_pkg;

   localparam int OP_BITS  = 3;
   localparam int SRC_BITS = 6;
   localparam int SLOT_BITS = 5;
   localparam int PC_BITS  = 7;

   localparam logic [OP_BITS-1:0] OP_MUL = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ADD = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SUB = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
   localparam logic [OP_BITS-1:0] OP_OUT = 3'd4;

   // operand sources
   localparam logic [SRC_BITS-1:0] S_F00  = 6'd0;
   localparam logic [SRC_BITS-1:0] S_F01  = 6'd1;
   localparam logic [SRC_BITS-1:0] S_F10  = 6'd2;
   localparam logic [SRC_BITS-1:0] S_F11  = 6'd3;
   localparam logic [SRC_BITS-1:0] S_QP   = 6'd4;
   localparam logic [SRC_BITS-1:0] S_QC   = 6'd5;
   localparam logic [SRC_BITS-1:0] S_QV   = 6'd6;
   localparam logic [SRC_BITS-1:0] S_R    = 6'd7;
   localparam logic [SRC_BITS-1:0] S_Z    = 6'd8;
   localparam logic [SRC_BITS-1:0] S_U0   = 6'd9;
   localparam logic [SRC_BITS-1:0] S_U1   = 6'd10;
   localparam logic [SRC_BITS-1:0] S_ONE  = 6'd11;
   localparam logic [SRC_BITS-1:0] S_ZERO = 6'd12;
   // scratch memory slots (bit 5 set)
   localparam logic [SRC_BITS-1:0] M_POS = 6'd32;
   localparam logic [SRC_BITS-1:0] M_VEL = 6'd33;
   localparam logic [SRC_BITS-1:0] M_C0  = 6'd34;
   localparam logic [SRC_BITS-1:0] M_C1  = 6'd35;
   localparam logic [SRC_BITS-1:0] M_C2  = 6'd36;
   localparam logic [SRC_BITS-1:0] M_C3  = 6'd37;
   localparam logic [SRC_BITS-1:0] M_X0  = 6'd38;
   localparam logic [SRC_BITS-1:0] M_X1  = 6'd39;
   localparam logic [SRC_BITS-1:0] M_A00 = 6'd40;
   localparam logic [SRC_BITS-1:0] M_A01 = 6'd41;
   localparam logic [SRC_BITS-1:0] M_A10 = 6'd42;
   localparam logic [SRC_BITS-1:0] M_A11 = 6'd43;
   localparam logic [SRC_BITS-1:0] M_P00 = 6'd44;
   localparam logic [SRC_BITS-1:0] M_P01 = 6'd45;
   localparam logic [SRC_BITS-1:0] M_P10 = 6'd46;
   localparam logic [SRC_BITS-1:0] M_P11 = 6'd47;
   localparam logic [SRC_BITS-1:0] M_D   = 6'd48;
   localparam logic [SRC_BITS-1:0] M_K0  = 6'd49;
   localparam logic [SRC_BITS-1:0] M_K1  = 6'd50;
   localparam logic [SRC_BITS-1:0] M_E   = 6'd51;
   localparam logic [SRC_BITS-1:0] M_M00 = 6'd52;
   localparam logic [SRC_BITS-1:0] M_NK1 = 6'd53;
   localparam logic [SRC_BITS-1:0] M_D00 = 6'd54;
   localparam logic [SRC_BITS-1:0] M_D01 = 6'd55;
   localparam logic [SRC_BITS-1:0] M_D10 = 6'd56;
   localparam logic [SRC_BITS-1:0] M_D11 = 6'd57;
   localparam logic [SRC_BITS-1:0] M_G0R = 6'd58;
   localparam logic [SRC_BITS-1:0] M_G1R = 6'd59;
   localparam logic [SRC_BITS-1:0] M_T0  = 6'd60;
   localparam logic [SRC_BITS-1:0] M_T1  = 6'd61;

   localparam logic [PC_BITS-1:0] PC_LAST = 7'd68;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [SRC_BITS-1:0] src_a;
      logic [SRC_BITS-1:0] src_b;
      logic [SLOT_BITS-1:0] dst;
   } instr_type;

   typedef struct packed {
      logic      start;
      logic      valid;
      instr_type instr;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } status_type;

   function automatic instr_type mk(input logic [OP_BITS-1:0] op,
                                    input logic [SRC_BITS-1:0] a,
                                    input logic [SRC_BITS-1:0] b,
                                    input logic [SRC_BITS-1:0] d);
      instr_type i;
      i.op    = op;
      i.src_a = a;
      i.src_b = b;
      i.dst   = d[SLOT_BITS-1:0];
      return i;
   endfunction

   function automatic instr_type program_rom(input logic [PC_BITS-1:0] pc);
      instr_type i;
      case (pc)
         7'd0:  i = mk(OP_MUL, S_F00, M_POS, M_T0);
         7'd1:  i = mk(OP_MUL, S_F01, M_VEL, M_T1);
         7'd2:  i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd3:  i = mk(OP_ADD, M_T0, S_U0, M_X0);
         7'd4:  i = mk(OP_MUL, S_F10, M_POS, M_T0);
         7'd5:  i = mk(OP_MUL, S_F11, M_VEL, M_T1);
         7'd6:  i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd7:  i = mk(OP_ADD, M_T0, S_U1, M_X1);
         7'd8:  i = mk(OP_MUL, S_F00, M_C0, M_T0);
         7'd9:  i = mk(OP_MUL, S_F01, M_C2, M_T1);
         7'd10: i = mk(OP_ADD, M_T0, M_T1, M_A00);
         7'd11: i = mk(OP_MUL, S_F00, M_C1, M_T0);
         7'd12: i = mk(OP_MUL, S_F01, M_C3, M_T1);
         7'd13: i = mk(OP_ADD, M_T0, M_T1, M_A01);
         7'd14: i = mk(OP_MUL, S_F10, M_C0, M_T0);
         7'd15: i = mk(OP_MUL, S_F11, M_C2, M_T1);
         7'd16: i = mk(OP_ADD, M_T0, M_T1, M_A10);
         7'd17: i = mk(OP_MUL, S_F10, M_C1, M_T0);
         7'd18: i = mk(OP_MUL, S_F11, M_C3, M_T1);
         7'd19: i = mk(OP_ADD, M_T0, M_T1, M_A11);
         7'd20: i = mk(OP_MUL, M_A00, S_F00, M_T0);
         7'd21: i = mk(OP_MUL, M_A01, S_F01, M_T1);
         7'd22: i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd23: i = mk(OP_ADD, M_T0, S_QP, M_P00);
         7'd24: i = mk(OP_MUL, M_A00, S_F10, M_T0);
         7'd25: i = mk(OP_MUL, M_A01, S_F11, M_T1);
         7'd26: i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd27: i = mk(OP_ADD, M_T0, S_QC, M_P01);
         7'd28: i = mk(OP_MUL, M_A10, S_F00, M_T0);
         7'd29: i = mk(OP_MUL, M_A11, S_F01, M_T1);
         7'd30: i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd31: i = mk(OP_ADD, M_T0, S_QC, M_P10);
         7'd32: i = mk(OP_MUL, M_A10, S_F10, M_T0);
         7'd33: i = mk(OP_MUL, M_A11, S_F11, M_T1);
         7'd34: i = mk(OP_ADD, M_T0, M_T1, M_T0);
         7'd35: i = mk(OP_ADD, M_T0, S_QV, M_P11);
         7'd36: i = mk(OP_ADD, M_P00, S_R, M_D);
         7'd37: i = mk(OP_DIV, M_P00, M_D, M_K0);
         7'd38: i = mk(OP_DIV, M_P10, M_D, M_K1);
         7'd39: i = mk(OP_SUB, S_Z, M_X0, M_E);
         7'd40: i = mk(OP_MUL, M_K0, M_E, M_T0);
         7'd41: i = mk(OP_ADD, M_X0, M_T0, M_POS);
         7'd42: i = mk(OP_MUL, M_K1, M_E, M_T1);
         7'd43: i = mk(OP_ADD, M_X1, M_T1, M_VEL);
         7'd44: i = mk(OP_SUB, S_ONE, M_K0, M_M00);
         7'd45: i = mk(OP_SUB, S_ZERO, M_K1, M_NK1);
         7'd46: i = mk(OP_MUL, M_P00, M_M00, M_D00);
         7'd47: i = mk(OP_MUL, M_P01, M_M00, M_D01);
         7'd48: i = mk(OP_MUL, M_P00, M_NK1, M_T0);
         7'd49: i = mk(OP_ADD, M_T0, M_P10, M_D10);
         7'd50: i = mk(OP_MUL, M_P01, M_NK1, M_T0);
         7'd51: i = mk(OP_ADD, M_T0, M_P11, M_D11);
         7'd52: i = mk(OP_MUL, M_K0, S_R, M_G0R);
         7'd53: i = mk(OP_MUL, M_K1, S_R, M_G1R);
         7'd54: i = mk(OP_MUL, M_D00, M_M00, M_T0);
         7'd55: i = mk(OP_MUL, M_G0R, M_K0, M_T1);
         7'd56: i = mk(OP_ADD, M_T0, M_T1, M_C0);
         7'd57: i = mk(OP_MUL, M_D00, M_NK1, M_T0);
         7'd58: i = mk(OP_ADD, M_T0, M_D01, M_T0);
         7'd59: i = mk(OP_MUL, M_G0R, M_K1, M_T1);
         7'd60: i = mk(OP_ADD, M_T0, M_T1, M_C1);
         7'd61: i = mk(OP_MUL, M_D10, M_M00, M_T0);
         7'd62: i = mk(OP_MUL, M_G1R, M_K0, M_T1);
         7'd63: i = mk(OP_ADD, M_T0, M_T1, M_C2);
         7'd64: i = mk(OP_MUL, M_D10, M_NK1, M_T0);
         7'd65: i = mk(OP_ADD, M_T0, M_D11, M_T0);
         7'd66: i = mk(OP_MUL, M_G1R, M_K1, M_T1);
         7'd67: i = mk(OP_ADD, M_T0, M_T1, M_C3);
         7'd68: i = mk(OP_OUT, M_POS, M_VEL, M_T0);
         default: i = mk(OP_OUT, M_POS, M_VEL, M_T0);
      endcase
      return i;
   endfunction

endpackage

// ===== hw/rtl/kfp_divider.sv =====
module kfp_divider import kfp_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] numer,
   input  logic signed [WORD_BITS-1:0] denom,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] quot,
   output logic                        clamp
);

   localparam int W  = WORD_BITS;
   localparam int N  = WORD_BITS + FRAC_BITS;
   localparam int CW = $clog2(N + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  ud_ff, ud_in;
   logic [N-1:0]  num_ff, num_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [N-1:0]  q_ff, q_in;
   logic signed [W-1:0] res_ff, res_in;
   logic          clamp_ff, clamp_in;

   logic [W:0]   r2;
   logic         ge;
   logic [W-1:0] un, udn;
   logic [N-1:0] lim;

   always_comb begin
      un  = numer[W-1] ? W'(-numer) : W'(numer);
      udn = denom[W-1] ? W'(-denom) : W'(denom);
      r2  = {rem_ff, num_ff[N-1]};
      ge  = r2 >= {1'b0, ud_ff};
      lim = neg_ff ? (N'(1) << (W-1)) : ((N'(1) << (W-1)) - N'(1));

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      ud_in    = ud_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      clamp_in = clamp_ff;

      if (start) begin
         neg_in = numer[W-1] != denom[W-1];
         ud_in  = udn;
         num_in = {un, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         q_in   = '0;
         cnt_in = CW'(N);
         if (denom == '0) begin
            res_in   = '0;
            clamp_in = 1'b1;
            done_in  = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (q_ff > lim) begin
               clamp_in = 1'b1;
               res_in   = neg_ff ? W'(-lim) : W'(lim);
            end else begin
               clamp_in = 1'b0;
               res_in   = neg_ff ? W'(-q_ff) : W'(q_ff);
            end
         end else begin
            rem_in = ge ? W'(r2 - {1'b0, ud_ff}) : W'(r2);
            q_in   = {q_ff[N-2:0], ge};
            num_in = {num_ff[N-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      ud_ff    <= ud_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
      clamp_ff <= clamp_in;
   end

   assign done  = done_ff;
   assign quot  = res_ff;
   assign clamp = clamp_ff;

endmodule

// ===== hw/rtl/kfp_datapath.sv =====
module kfp_datapath import kfp_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_control_position,
   input  logic signed [31:0] req_control_velocity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position_estimate,
   output logic signed [31:0] rsp_velocity_estimate,
   output logic               rsp_saturated
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int SLOTS = 2 ** SLOT_BITS;
   localparam longint WMAX_L = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam longint WMIN_L = -WMAX_L - 64'sd1;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W:0] clamp_in(input longint v);
      logic [W:0] r;
      if (v > WMAX_L) begin
         r = {1'b1, WMAX};
      end else if (v < WMIN_L) begin
         r = {1'b1, WMIN};
      end else begin
         r = {1'b0, W'(v)};
      end
      return r;
   endfunction

   function automatic logic [W:0] sat_sum(input logic signed [W:0] v);
      logic [W:0] r;
      if (v[W] != v[W-1]) begin
         r = {1'b1, v[W] ? WMIN : WMAX};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   // configuration
   logic [31:0] cfg_ff [8];
   logic [W-1:0] cfg_w [8];
   logic [7:0]   cfg_over;
   logic [W:0]   cfg_c [8];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (i == 4 || i == 6 || i == 7) begin
            cfg_c[i] = clamp_in(longint'({1'b0, cfg_ff[i][30:0]}));
         end else begin
            cfg_c[i] = clamp_in(longint'(signed'(cfg_ff[i])));
         end
         cfg_w[i]    = cfg_c[i][W-1:0];
         cfg_over[i] = cfg_c[i][W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= 32'd65536;
         cfg_ff[1] <= 32'd0;
         cfg_ff[2] <= 32'd0;
         cfg_ff[3] <= 32'd65536;
         cfg_ff[4] <= 32'd66;
         cfg_ff[5] <= 32'd0;
         cfg_ff[6] <= 32'd66;
         cfg_ff[7] <= 32'd65536;
      end else if (csr_write_enable) begin
         cfg_ff[csr_index] <= csr_write_data;
      end
   end

   // inputs
   logic [W-1:0] z_ff, u0_ff, u1_ff;
   logic [W:0]   z_c, u0_c, u1_c;
   logic         clamp_ff, clamp_in_v;

   assign z_c  = clamp_in(longint'(req_measured_position));
   assign u0_c = clamp_in(longint'(req_control_position));
   assign u1_c = clamp_in(longint'(req_control_velocity));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         z_ff  <= z_c[W-1:0];
         u0_ff <= u0_c[W-1:0];
         u1_ff <= u1_c[W-1:0];
      end
   end

   function automatic logic [W-1:0] pick(input logic [SRC_BITS-1:0] s);
      logic [W-1:0] v;
      case (s)
         S_F00:  v = cfg_w[0];
         S_F01:  v = cfg_w[1];
         S_F10:  v = cfg_w[2];
         S_F11:  v = cfg_w[3];
         S_QP:   v = cfg_w[4];
         S_QC:   v = cfg_w[5];
         S_QV:   v = cfg_w[6];
         S_R:    v = cfg_w[7];
         S_Z:    v = z_ff;
         S_U0:   v = u0_ff;
         S_U1:   v = u1_ff;
         S_ONE:  v = W'(1) << F;
         S_ZERO: v = '0;
         default: v = '0;
      endcase
      return v;
   endfunction

   // scratch memory, valid bits give the zero reset of the filter state
   logic [W-1:0] mem [SLOTS];
   logic [SLOTS-1:0] mvld_ff;
   logic [W-1:0] mem_a_ff, mem_b_ff, oth_a_ff, oth_b_ff;
   logic         isa_ff, isb_ff, va_ff, vb_ff;
   logic         s1_ff;
   logic [OP_BITS-1:0]   op1_ff;
   logic [SLOT_BITS-1:0] dst1_ff;

   logic         wr_en;
   logic [SLOT_BITS-1:0] wr_slot;
   logic [W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      mem_a_ff <= mem[cmd.instr.src_a[SLOT_BITS-1:0]];
      mem_b_ff <= mem[cmd.instr.src_b[SLOT_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= '0;
         s1_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            mvld_ff[wr_slot] <= 1'b1;
         end
         s1_ff <= cmd.valid;
      end
      va_ff    <= mvld_ff[cmd.instr.src_a[SLOT_BITS-1:0]];
      vb_ff    <= mvld_ff[cmd.instr.src_b[SLOT_BITS-1:0]];
      isa_ff   <= cmd.instr.src_a[SRC_BITS-1];
      isb_ff   <= cmd.instr.src_b[SRC_BITS-1];
      oth_a_ff <= pick(cmd.instr.src_a);
      oth_b_ff <= pick(cmd.instr.src_b);
      op1_ff   <= cmd.instr.op;
      dst1_ff  <= cmd.instr.dst;
   end

   logic signed [W-1:0] a_val, b_val;
   assign a_val = isa_ff ? (va_ff ? mem_a_ff : '0) : oth_a_ff;
   assign b_val = isb_ff ? (vb_ff ? mem_b_ff : '0) : oth_b_ff;

   // execute stage
   logic [W-1:0]    ma, mb;
   logic [2*W-1:0]  prod_ff;
   logic            neg_ff, ismul_ff, s2_ff;
   logic signed [W:0] sum_ff;
   logic [SLOT_BITS-1:0] dst2_ff;
   logic            div_start, div_done, div_clamp;
   logic signed [W-1:0] div_q;
   logic            out_now;

   assign ma = a_val[W-1] ? W'(-a_val) : W'(a_val);
   assign mb = b_val[W-1] ? W'(-b_val) : W'(b_val);
   assign div_start = s1_ff && (op1_ff == OP_DIV);
   assign out_now   = s1_ff && (op1_ff == OP_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= 1'b0;
      end else begin
         s2_ff <= s1_ff && (op1_ff == OP_MUL || op1_ff == OP_ADD || op1_ff == OP_SUB);
      end
      prod_ff  <= ma * mb;
      neg_ff   <= a_val[W-1] != b_val[W-1];
      ismul_ff <= op1_ff == OP_MUL;
      sum_ff   <= (op1_ff == OP_SUB) ? ((W+1)'(a_val) - (W+1)'(b_val))
                                     : ((W+1)'(a_val) + (W+1)'(b_val));
      dst2_ff  <= dst1_ff;
   end

   kfp_divider #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (a_val),
      .denom (b_val),
      .done  (div_done),
      .quot  (div_q),
      .clamp (div_clamp)
   );

   // round and saturate, write back
   logic [2*W:0]    rnd;
   logic [2*W:0]    lim;
   logic [W-1:0]    mul_res;
   logic            mul_over;
   logic [W:0]      sum_c;
   logic            wr_clamp;

   always_comb begin
      rnd = ({1'b0, prod_ff} + ((2*W+1)'(1) << (F - 1))) >> F;
      lim = neg_ff ? ((2*W+1)'(1) << (W - 1)) : (((2*W+1)'(1) << (W - 1)) - (2*W+1)'(1));
      mul_over = rnd > lim;
      if (mul_over) begin
         mul_res = neg_ff ? W'(-lim) : W'(lim);
      end else begin
         mul_res = neg_ff ? W'(-rnd) : W'(rnd);
      end
      sum_c = sat_sum(sum_ff);

      wr_en    = s2_ff || div_done;
      wr_slot  = dst2_ff;
      wr_data  = mul_res;
      wr_clamp = 1'b0;
      if (div_done) begin
         wr_slot  = dst1_ff;
         wr_data  = div_q;
         wr_clamp = div_clamp;
      end else if (ismul_ff) begin
         wr_clamp = mul_over;
      end else begin
         wr_data  = sum_c[W-1:0];
         wr_clamp = sum_c[W];
      end
   end

   // result register
   logic        rv_ff;
   logic [31:0] rpos_ff, rvel_ff;
   logic        rsat_ff;
   logic [32:0] pos_o, vel_o;

   always_comb begin
      if (W > 32) begin
         pos_o = {(longint'(a_val) > longint'(32'sh7FFFFFFF)) ||
                  (longint'(a_val) < -longint'(33'sh080000000)),
                  32'(a_val)};
         vel_o = {(longint'(b_val) > longint'(32'sh7FFFFFFF)) ||
                  (longint'(b_val) < -longint'(33'sh080000000)),
                  32'(b_val)};
         if (pos_o[32]) begin
            pos_o[31:0] = a_val[W-1] ? 32'h80000000 : 32'h7FFFFFFF;
         end
         if (vel_o[32]) begin
            vel_o[31:0] = b_val[W-1] ? 32'h80000000 : 32'h7FFFFFFF;
         end
      end else begin
         pos_o = {1'b0, 32'(a_val)};
         vel_o = {1'b0, 32'(b_val)};
      end
   end

   always_comb begin
      clamp_in_v = clamp_ff;
      if (cmd.start) begin
         clamp_in_v = (|cfg_over) | z_c[W] | u0_c[W] | u1_c[W];
      end else if (wr_en && wr_clamp) begin
         clamp_in_v = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= 1'b0;
         clamp_ff <= 1'b0;
      end else begin
         clamp_ff <= clamp_in_v;
         if (out_now) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
      if (out_now) begin
         rpos_ff <= pos_o[31:0];
         rvel_ff <= vel_o[31:0];
         rsat_ff <= clamp_ff | pos_o[32] | vel_o[32];
      end
   end

   assign rsp_valid             = rv_ff;
   assign rsp_position_estimate = rpos_ff;
   assign rsp_velocity_estimate = rvel_ff;
   assign rsp_saturated         = rsat_ff;
   assign status.done           = wr_en || out_now;
   assign status.out_free       = !rv_ff;

endmodule

// ===== hw/rtl/kfp_controller.sv =====
module kfp_controller import kfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   instr_type          instr;
   logic               accept;

   assign instr     = program_rom(pc_ff);
   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      cmd.start = accept;
      cmd.valid = 1'b0;
      cmd.instr = instr;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pc_in    = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (instr.op != OP_OUT || status.out_free) begin
               cmd.valid = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.done) begin
               if (pc_ff == PC_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/kalman_filter_2state_position.sv =====
// Two-state (position, velocity) Kalman filter in signed fixed point. Each
// transfer on req runs one predict, gain and Joseph-form correct cycle and
// returns one transfer on rsp. A microprogram of 69 steps drives a single
// multiply/add datapath and a restoring divider that forms the two gain
// divisions, on the default Q16.16 word. The output step waits while a
// previous result is still held in the rsp register. req is taken only
// while no item is in progress; a finished result waits in the rsp
// register. Configuration is to be written by the user only while the
// block is idle; the block itself does not enforce this.
`include "kalman_filter_2state_position_defines.svh"
module kalman_filter_2state_position import kfp_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_control_position,
   input  logic signed [31:0] req_control_velocity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position_estimate,
   output logic signed [31:0] rsp_velocity_estimate,
   output logic               rsp_saturated
);

   cmd_type    cmd;
   status_type status;

   kfp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   kfp_datapath #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_measured_position (req_measured_position),
      .req_control_position  (req_control_position),
      .req_control_velocity  (req_control_velocity),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_position_estimate (rsp_position_estimate),
      .rsp_velocity_estimate (rsp_velocity_estimate),
      .rsp_saturated         (rsp_saturated)
   );

   `KFP_ASSERT_NEXT(busy_after_accept, req_valid && !req_stall, req_stall)
   `KFP_ASSERT_NEXT(no_early_result, req_valid && !req_stall, !$rose(rsp_valid))
   `KFP_ASSERT_SAME(result_ends_item, $rose(rsp_valid), !req_stall)

endmodule

// ===== test/kfp_tb_pkg.sv =====
package kfp_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      REG_F00      = 3'd0,
      REG_F01      = 3'd1,
      REG_F10      = 3'd2,
      REG_F11      = 3'd3,
      REG_Q_POS    = 3'd4,
      REG_Q_CROSS  = 3'd5,
      REG_Q_VEL    = 3'd6,
      REG_R        = 3'd7
   } csr_index_type;

endpackage

// ===== test/kalman_filter_2state_position_checker.sv =====
module kalman_filter_2state_position_checker import kfp_tb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_control_position,
   input  logic signed [31:0] req_control_velocity,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_position_estimate,
   input  logic signed [31:0] rsp_velocity_estimate,
   input  logic               rsp_saturated,
   output int                 mismatches,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint ONE  = 64'sd65536;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic               saturated;
   } estimate_type;

   estimate_type estimate_q[$];
   longint       csr_model[8];
   longint       pos_state, vel_state;
   longint       cov[4];
   bit           clamp_hit;

   function automatic longint clip(input longint v);
      if (v > WMAX) begin
         clamp_hit = 1;
         return WMAX;
      end
      if (v < WMIN) begin
         clamp_hit = 1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint add2(input longint a, input longint b);
      return clip(a + b);
   endfunction

   function automatic longint from_mag(input bit neg, input longint unsigned m);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) begin
         clamp_hit = 1;
         m = lim;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      longint unsigned ua, ub;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return from_mag((a < 0) != (b < 0), (ua * ub + 64'd32768) >> 16);
   endfunction

   function automatic longint fx_div(input longint n, input longint d);
      longint unsigned un, ud, q, r;
      if (d == 0) begin
         clamp_hit = 1;
         return 0;
      end
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = un / ud;
      r = un % ud;
      for (int i = 0; i < 16; i++) begin
         if (q > 64'd2147483648) q = 64'd2147483649;
         q = q << 1;
         r = r << 1;
         if (r >= ud) begin
            r = r - ud;
            q = q | 1;
         end
      end
      return from_mag((n < 0) != (d < 0), q);
   endfunction

   function automatic estimate_type kalman_update(input longint z, input longint u0,
                                                  input longint u1);
      longint f00, f01, f10, f11, qp, qc, qv, r;
      longint x0, x1, a00, a01, a10, a11, p00, p01, p10, p11;
      longint d, k0, k1, e, m00, nk1, c00, c01, c10, c11, g0r, g1r;
      estimate_type res;
      clamp_hit = 0;
      f00 = csr_model[REG_F00];
      f01 = csr_model[REG_F01];
      f10 = csr_model[REG_F10];
      f11 = csr_model[REG_F11];
      qp = csr_model[REG_Q_POS];
      qc = csr_model[REG_Q_CROSS];
      qv = csr_model[REG_Q_VEL];
      r = csr_model[REG_R];
      x0 = add2(add2(fx_mul(f00, pos_state), fx_mul(f01, vel_state)), u0);
      x1 = add2(add2(fx_mul(f10, pos_state), fx_mul(f11, vel_state)), u1);
      a00 = add2(fx_mul(f00, cov[0]), fx_mul(f01, cov[2]));
      a01 = add2(fx_mul(f00, cov[1]), fx_mul(f01, cov[3]));
      a10 = add2(fx_mul(f10, cov[0]), fx_mul(f11, cov[2]));
      a11 = add2(fx_mul(f10, cov[1]), fx_mul(f11, cov[3]));
      p00 = add2(add2(fx_mul(a00, f00), fx_mul(a01, f01)), qp);
      p01 = add2(add2(fx_mul(a00, f10), fx_mul(a01, f11)), qc);
      p10 = add2(add2(fx_mul(a10, f00), fx_mul(a11, f01)), qc);
      p11 = add2(add2(fx_mul(a10, f10), fx_mul(a11, f11)), qv);
      d = add2(p00, r);
      k0 = fx_div(p00, d);
      k1 = fx_div(p10, d);
      e = clip(z - x0);
      x0 = add2(x0, fx_mul(k0, e));
      x1 = add2(x1, fx_mul(k1, e));
      m00 = clip(ONE - k0);
      nk1 = clip(-k1);
      c00 = fx_mul(p00, m00);
      c01 = fx_mul(p01, m00);
      c10 = add2(fx_mul(p00, nk1), p10);
      c11 = add2(fx_mul(p01, nk1), p11);
      g0r = fx_mul(k0, r);
      g1r = fx_mul(k1, r);
      cov[0] = add2(fx_mul(c00, m00), fx_mul(g0r, k0));
      cov[1] = add2(add2(fx_mul(c00, nk1), c01), fx_mul(g0r, k1));
      cov[2] = add2(fx_mul(c10, m00), fx_mul(g1r, k0));
      cov[3] = add2(add2(fx_mul(c10, nk1), c11), fx_mul(g1r, k1));
      pos_state = x0;
      vel_state = x1;
      res.position = x0[31:0];
      res.velocity = x1[31:0];
      res.saturated = clamp_hit;
      return res;
   endfunction

   assign pending = estimate_q.size();

   always @(posedge clock) begin
      estimate_type exp_est;
      if (reset) begin
         csr_model = '{65536, 0, 0, 65536, 66, 0, 66, 65536};
         pos_state = 0;
         vel_state = 0;
         cov = '{0, 0, 0, 0};
         estimate_q.delete();
         mismatches = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_Q_POS || csr_index == REG_Q_VEL || csr_index == REG_R)
               csr_model[csr_index] = longint'({1'b0, csr_write_data[30:0]});
            else
               csr_model[csr_index] = longint'(signed'(csr_write_data));
         end
         if (req_valid && !req_stall)
            estimate_q.push_back(kalman_update(req_measured_position,
                                               req_control_position,
                                               req_control_velocity));
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected rsp transfer pos=%0d vel=%0d", $realtime,
                           rsp_position_estimate, rsp_velocity_estimate);
            end else begin
               exp_est = estimate_q.pop_front();
               if (rsp_position_estimate !== exp_est.position ||
                   rsp_velocity_estimate !== exp_est.velocity ||
                   rsp_saturated !== exp_est.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t: rsp mismatch exp pos=%0d vel=%0d sat=%0b, got %0d %0d %0b",
                              $realtime, exp_est.position, exp_est.velocity,
                              exp_est.saturated, rsp_position_estimate,
                              rsp_velocity_estimate, rsp_saturated);
               end
            end
         end
      end
   end

endmodule

// ===== test/kalman_filter_2state_position_tb.sv =====
module kalman_filter_2state_position_tb import kfp_tb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write_enable = 0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_measured_position = '0;
   logic signed [31:0] req_control_position = '0;
   logic signed [31:0] req_control_velocity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_position_estimate;
   logic signed [31:0] rsp_velocity_estimate;
   logic               rsp_saturated;
   int                 mismatches;
   int                 pending;
   int                 idle_cycles = 0;
   int                 stall_left = 0;
   bit                 no_gaps = 0;

   always #5 clock = ~clock;

   kalman_filter_2state_position u_dut (.*);

   kalman_filter_2state_position_checker u_checker (.*);

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_gaps || roll < 45) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(80, 15);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(2) == 0);
         stall_left <= pick_gap();
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic send_measurement(input logic [31:0] z, input logic [31:0] u0,
                                   input logic [31:0] u1);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_measured_position <= z;
      req_control_position <= u0;
      req_control_velocity <= u1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) write_csr(csr_index_type'(i), vals[i]);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] small_signed(input int span);
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 15)
            send_measurement($urandom, $urandom, $urandom);
         else
            send_measurement(small_signed(1 << 22), small_signed(1 << 14),
                             small_signed(1 << 12));
      end
   endtask

   initial begin
      logic [31:0] cfg[8];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed with reset configuration
      send_measurement(32'sh0000_0000, 32'sh0, 32'sh0);
      send_measurement(32'sh7fff_ffff, 32'sh0, 32'sh0);
      send_measurement(32'sh8000_0000, 32'sh0, 32'sh0);
      send_measurement(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_measurement(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_measurement(32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff);
      send_measurement(32'shffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      send_measurement(32'sh0, 32'sh0, 32'sh0);
      for (int n = 0; n < 8; n++)
         send_measurement(32'sh0001_0000 * n, 32'sh0000_8000, 32'shffff_ffff);
      random_items(80);
      drain();

      // extremes
      cfg = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      load_config(cfg);
      send_measurement(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      random_items(40);
      drain();
      cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h0, 32'h8000_0000, 32'h0, 32'h1};
      load_config(cfg);
      send_measurement(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
      random_items(40);
      drain();
      // zero noise, minimum R, negative cross term
      cfg = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
              32'h0, 32'hffff_0000, 32'h0, 32'h1};
      load_config(cfg);
      random_items(40);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         no_gaps = (ph % 4 == 3);
         if (ph == 9) begin
            foreach (cfg[i]) cfg[i] = $urandom;
         end else begin
            cfg[REG_F00] = 32'h0001_0000 + small_signed(1 << 11);
            cfg[REG_F01] = $urandom_range(32'h0001_0000);
            cfg[REG_F10] = small_signed(1 << 10);
            cfg[REG_F11] = 32'h0001_0000 + small_signed(1 << 11);
            cfg[REG_Q_POS] = $urandom_range(1 << 12);
            cfg[REG_Q_CROSS] = small_signed(1 << 10);
            cfg[REG_Q_VEL] = $urandom_range(1 << 12);
            cfg[REG_R] = $urandom_range(1 << 20, 1);
         end
         load_config(cfg);
         random_items(72);
         drain();
      end
      no_gaps = 0;

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
